// ----- design/sal_pkg.sv -----
package sal_pkg;

    localparam int SIDE_W    = 13;
    localparam int CALC_W    = 16;
    localparam int STAMP_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int MIN_SIDE  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAGES   = 2'd2;

    localparam logic [SIDE_W-1:0] RST_PAGE_WIDTH  = 13'd1024;
    localparam logic [SIDE_W-1:0] RST_PAGE_HEIGHT = 13'd1024;
    localparam logic [3:0]        RST_MAX_PAGES   = 4'd8;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_TOUCH = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EVICTED   = 2'd1;
    localparam logic [1:0] STAT_NO_ROOM   = 2'd2;
    localparam logic [1:0] STAT_TOO_LARGE = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [SIDE_W-1:0] block_width;
        logic [SIDE_W-1:0] block_height;
        logic [2:0]        page_index;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  placed_page;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
    } res_t;

    typedef struct packed {
        logic fits_row;
        logic fits_next_row;
        logic lru_take;
    } fit_t;

endpackage

// ----- design/sal_fit_unit.sv -----
module sal_fit_unit (
    input  logic [sal_pkg::SIDE_W-1:0]  cursor_x,
    input  logic [sal_pkg::SIDE_W-1:0]  cursor_y,
    input  logic [sal_pkg::SIDE_W-1:0]  row_height,
    input  logic [sal_pkg::STAMP_W-1:0] last_use,
    input  logic [sal_pkg::SIDE_W-1:0]  block_width,
    input  logic [sal_pkg::SIDE_W-1:0]  block_height,
    input  logic [sal_pkg::SIDE_W-1:0]  page_w,
    input  logic [sal_pkg::SIDE_W-1:0]  page_h,
    input  logic [sal_pkg::STAMP_W-1:0] use_count,
    input  logic [sal_pkg::STAMP_W-1:0] best,
    input  logic                        have,
    output sal_pkg::fit_t               fit
);

    logic [sal_pkg::CALC_W-1:0] row_x_end;
    logic [sal_pkg::CALC_W-1:0] row_y_end;
    logic [sal_pkg::CALC_W-1:0] next_y_end;

    always_comb
    begin
        row_x_end  = sal_pkg::CALC_W'(cursor_x) + sal_pkg::CALC_W'(block_width)
                   + sal_pkg::CALC_W'(1);
        row_y_end  = sal_pkg::CALC_W'(cursor_y) + sal_pkg::CALC_W'(block_height)
                   + sal_pkg::CALC_W'(1);
        next_y_end = sal_pkg::CALC_W'(cursor_y) + sal_pkg::CALC_W'(row_height)
                   + sal_pkg::CALC_W'(block_height) + sal_pkg::CALC_W'(2);
        fit.fits_row      = (row_x_end <= sal_pkg::CALC_W'(page_w))
                         && (row_y_end <= sal_pkg::CALC_W'(page_h));
        fit.fits_next_row = next_y_end <= sal_pkg::CALC_W'(page_h);
        fit.lru_take      = (last_use != use_count) && (!have || (last_use < best));
    end

endmodule

// ----- design/shelf_atlas_allocator_lru.sv -----
// Channel   Direction  Handshake                  Payload
// request   in         start / busy               req    (sal_pkg::req_t)
// result    out        done (one-cycle strobe)    result (sal_pkg::res_t)
// config    in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Tick, touch, clear and oversized allocates finish at the accept edge; done strobes the
// next cycle. An allocate scans one open page per cycle through the shared fit unit, then,
// if no page fits and none can be opened, scans again for the LRU victim; busy holds until
// the placement or the no-room answer, and done follows. The page store has one read port.
// Reset restores control and config registers only; page entries are written when a page opens.
// The result side cannot stall; result is held until the next request is accepted, and done marks it.
module shelf_atlas_allocator_lru #(
    parameter int MAX_PAGES     = 8,
    parameter int MAX_PAGE_SIDE = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  sal_pkg::req_t                  req,
    output logic                           done,
    output sal_pkg::res_t                  result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sal_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sal_pkg::SIDE_W-1:0]     cfg_data
);

    localparam int CNT_W = $clog2(MAX_PAGES + 1);
    localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int SW    = sal_pkg::SIDE_W;
    localparam int CW    = sal_pkg::CALC_W;
    localparam int TW    = sal_pkg::STAMP_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FIT   = 4'b0010,
        ST_LRU   = 4'b0100,
        ST_PLACE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [SW-1:0]    page_width_reg, page_width_next;
    logic [SW-1:0]    page_height_reg, page_height_next;
    logic [3:0]       max_pages_reg, max_pages_next;
    logic [CNT_W-1:0] pages_open_reg, pages_open_next;
    logic [TW-1:0]    use_count_reg, use_count_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             have_reg, have_next;
    logic             done_reg, done_next;

    sal_pkg::req_t    req_reg, req_next;
    sal_pkg::res_t    result_reg, result_next;
    logic [IDX_W-1:0] sel_reg, sel_next;
    logic [TW-1:0]    best_reg, best_next;
    logic [SW-1:0]    base_x_reg, base_x_next;
    logic [SW-1:0]    base_y_reg, base_y_next;
    logic [SW-1:0]    base_rh_reg, base_rh_next;
    logic [1:0]       stat_reg, stat_next;

    logic [SW-1:0] cx_mem [MAX_PAGES];
    logic [SW-1:0] cy_mem [MAX_PAGES];
    logic [SW-1:0] rh_mem [MAX_PAGES];
    logic [TW-1:0] lu_mem [MAX_PAGES];

    logic [SW-1:0] cx_rd_reg, cy_rd_reg, rh_rd_reg;
    logic [TW-1:0] lu_rd_reg;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             geo_we, lu_we;
    logic [SW-1:0]    cx_wdata, cy_wdata, rh_wdata;

    logic [SW-1:0]    page_w, page_h;
    logic [CNT_W-1:0] lim;
    logic             too_large;
    logic             accept;
    logic [7:0]       touch_idx;
    logic [CW-1:0]    next_row_y;
    logic [7:0]       sel_ext;

    sal_pkg::fit_t    fit;

    sal_fit_unit u_fit (
        .cursor_x     (cx_rd_reg),
        .cursor_y     (cy_rd_reg),
        .row_height   (rh_rd_reg),
        .last_use     (lu_rd_reg),
        .block_width  (req_reg.block_width),
        .block_height (req_reg.block_height),
        .page_w       (page_w),
        .page_h       (page_h),
        .use_count    (use_count_reg),
        .best         (best_reg),
        .have         (have_reg),
        .fit          (fit)
    );

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (page_width_reg < SW'(sal_pkg::MIN_SIDE))
            page_w = SW'(sal_pkg::MIN_SIDE);
        else if (CW'(page_width_reg) > CW'(MAX_PAGE_SIDE))
            page_w = SW'(MAX_PAGE_SIDE);
        else
            page_w = page_width_reg;

        if (page_height_reg < SW'(sal_pkg::MIN_SIDE))
            page_h = SW'(sal_pkg::MIN_SIDE);
        else if (CW'(page_height_reg) > CW'(MAX_PAGE_SIDE))
            page_h = SW'(MAX_PAGE_SIDE);
        else
            page_h = page_height_reg;

        if (max_pages_reg == 4'd0)
            lim = CNT_W'(1);
        else if (8'(max_pages_reg) > 8'(MAX_PAGES))
            lim = CNT_W'(MAX_PAGES);
        else
            lim = CNT_W'(max_pages_reg);

        too_large = (CW'(req.block_width) + CW'(2) > CW'(page_w))
                 || (CW'(req.block_height) + CW'(2) > CW'(page_h));
        touch_idx  = 8'(req.page_index);
        next_row_y = CW'(cy_rd_reg) + CW'(rh_rd_reg) + CW'(1);
        sel_ext    = 8'(sel_reg);
    end

    always_comb
    begin
        page_width_next  = page_width_reg;
        page_height_next = page_height_reg;
        max_pages_next   = max_pages_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sal_pkg::REG_PAGE_WIDTH:  page_width_next  = cfg_data;
                sal_pkg::REG_PAGE_HEIGHT: page_height_next = cfg_data;
                sal_pkg::REG_MAX_PAGES:   max_pages_next   = cfg_data[3:0];
                default:                  page_width_next  = page_width_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pages_open_next = pages_open_reg;
        use_count_next  = use_count_reg;
        scan_idx_next   = scan_idx_reg;
        have_next       = have_reg;
        done_next       = 1'b0;
        req_next        = req_reg;
        result_next     = result_reg;
        sel_next        = sel_reg;
        best_next       = best_reg;
        base_x_next     = base_x_reg;
        base_y_next     = base_y_reg;
        base_rh_next    = base_rh_reg;
        stat_next       = stat_reg;
        wr_addr         = sel_reg;
        geo_we          = 1'b0;
        lu_we           = 1'b0;
        cx_wdata        = SW'(CW'(base_x_reg) + CW'(req_reg.block_width) + CW'(1));
        cy_wdata        = base_y_reg;
        rh_wdata        = (req_reg.block_height > base_rh_reg) ? req_reg.block_height
                                                                : base_rh_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next    = req;
                    result_next = '0;
                    case (req.req_type)
                        sal_pkg::REQ_TICK:
                        begin
                            if (use_count_reg != '1)
                                use_count_next = use_count_reg + TW'(1);
                            done_next = 1'b1;
                        end
                        sal_pkg::REQ_TOUCH:
                        begin
                            if (touch_idx < 8'(pages_open_reg))
                            begin
                                wr_addr = touch_idx[IDX_W-1:0];
                                lu_we   = 1'b1;
                            end
                            done_next = 1'b1;
                        end
                        sal_pkg::REQ_CLEAR:
                        begin
                            pages_open_next = '0;
                            done_next       = 1'b1;
                        end
                        default:
                        begin
                            if (too_large)
                            begin
                                result_next.status = sal_pkg::STAT_TOO_LARGE;
                                done_next          = 1'b1;
                            end
                            else
                            begin
                                scan_idx_next = '0;
                                state_next    = ST_FIT;
                            end
                        end
                    endcase
                end
            end

            ST_FIT:
            begin
                stat_next = sal_pkg::STAT_OK;
                if (scan_idx_reg < pages_open_reg)
                begin
                    sel_next = scan_idx_reg[IDX_W-1:0];
                    if (fit.fits_row)
                    begin
                        base_x_next  = cx_rd_reg;
                        base_y_next  = cy_rd_reg;
                        base_rh_next = rh_rd_reg;
                        state_next   = ST_PLACE;
                    end
                    else if (fit.fits_next_row)
                    begin
                        base_x_next  = SW'(1);
                        base_y_next  = SW'(next_row_y);
                        base_rh_next = '0;
                        state_next   = ST_PLACE;
                    end
                    else
                        scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                else if (pages_open_reg < lim)
                begin
                    sel_next        = pages_open_reg[IDX_W-1:0];
                    pages_open_next = pages_open_reg + CNT_W'(1);
                    base_x_next     = SW'(1);
                    base_y_next     = SW'(1);
                    base_rh_next    = '0;
                    state_next      = ST_PLACE;
                end
                else
                begin
                    scan_idx_next = '0;
                    have_next     = 1'b0;
                    state_next    = ST_LRU;
                end
            end

            ST_LRU:
            begin
                if (scan_idx_reg < pages_open_reg)
                begin
                    if (fit.lru_take)
                    begin
                        have_next = 1'b1;
                        best_next = lu_rd_reg;
                        sel_next  = scan_idx_reg[IDX_W-1:0];
                    end
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                else if (have_reg)
                begin
                    stat_next    = sal_pkg::STAT_EVICTED;
                    base_x_next  = SW'(1);
                    base_y_next  = SW'(1);
                    base_rh_next = '0;
                    state_next   = ST_PLACE;
                end
                else
                begin
                    result_next.status = sal_pkg::STAT_NO_ROOM;
                    done_next          = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            ST_PLACE:
            begin
                geo_we                  = 1'b1;
                lu_we                   = 1'b1;
                result_next.status      = stat_reg;
                result_next.placed_page = sel_ext[2:0];
                result_next.pos_x       = base_x_reg[11:0];
                result_next.pos_y       = base_y_reg[11:0];
                done_next               = 1'b1;
                state_next              = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_addr = scan_idx_next[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (geo_we)
        begin
            cx_mem[wr_addr] <= cx_wdata;
            cy_mem[wr_addr] <= cy_wdata;
            rh_mem[wr_addr] <= rh_wdata;
        end
        if (lu_we)
            lu_mem[wr_addr] <= use_count_reg;
        cx_rd_reg <= cx_mem[rd_addr];
        cy_rd_reg <= cy_mem[rd_addr];
        rh_rd_reg <= rh_mem[rd_addr];
        lu_rd_reg <= lu_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            page_width_reg  <= sal_pkg::RST_PAGE_WIDTH;
            page_height_reg <= sal_pkg::RST_PAGE_HEIGHT;
            max_pages_reg   <= sal_pkg::RST_MAX_PAGES;
            pages_open_reg  <= '0;
            use_count_reg   <= '0;
            scan_idx_reg    <= '0;
            have_reg        <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            page_width_reg  <= page_width_next;
            page_height_reg <= page_height_next;
            max_pages_reg   <= max_pages_next;
            pages_open_reg  <= pages_open_next;
            use_count_reg   <= use_count_next;
            scan_idx_reg    <= scan_idx_next;
            have_reg        <= have_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        result_reg  <= result_next;
        sel_reg     <= sel_next;
        best_reg    <= best_next;
        base_x_reg  <= base_x_next;
        base_y_reg  <= base_y_next;
        base_rh_reg <= base_rh_next;
        stat_reg    <= stat_next;
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted transaction neither started nor answered");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == sal_pkg::STAT_EVICTED) |-> pages_open_reg >= lim)
        else $error("eviction while a new page could open");

    a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PLACE) |-> (pages_open_reg != '0)
                                 && (CNT_W'(sel_reg) < pages_open_reg))
        else $error("placement into a page that is not open");

endmodule
